>>> rtl/core/matrix_multiply_row_range_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the matrix multiply row range block
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_ROW_RANGE_MACROS_SVH
`define MATRIX_MULTIPLY_ROW_RANGE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define MMRR_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define MMRR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`else

`define MMRR_ASSERT(lbl, cond, msg)

`define MMRR_ASSERT_IMP(lbl, ante, cons, msg)

`endif

`endif

>>> rtl/core/mmrr_pkg.sv
// ----------------------------------------------------------------------------
// Matrix multiply row range package
// Sizes, request codes, payload structs and the cell index helper.
// ----------------------------------------------------------------------------
package mmrr_pkg;

  localparam int DIM    = 16;
  localparam int CELLS  = DIM * DIM;
  localparam int ROW_W  = $clog2(DIM);
  localparam int IDX_W  = $clog2(CELLS);
  localparam int DATA_W = 32;

  localparam logic [2:0] REQ_WR_A = 3'd0;
  localparam logic [2:0] REQ_WR_B = 3'd1;
  localparam logic [2:0] REQ_WR_C = 3'd2;
  localparam logic [2:0] REQ_RUN  = 3'd3;
  localparam logic [2:0] REQ_RD_C = 3'd4;

  typedef struct packed {
    logic [2:0]               req_type;
    logic [3:0]               row;
    logic [3:0]               col;
    logic signed [DATA_W-1:0] value;
    logic [3:0]               first_row;
    logic [3:0]               last_row;
  } in_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic                     run_done;
  } out_resp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_RUN,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic             v;
    logic             first;
    logic             last;
    logic [IDX_W-1:0] cidx;
  } mac_issue_t;

  typedef struct packed {
    logic                     en;
    logic [IDX_W-1:0]         addr;
    logic signed [DATA_W-1:0] data;
  } mac_wr_t;

  function automatic logic [IDX_W-1:0] cell_idx(input int unsigned r, input int unsigned c);
    int unsigned p;
    p = r * DIM + c;
    return p[IDX_W-1:0];
  endfunction

endpackage

>>> rtl/core/matrix_multiply_row_range.sv
// ----------------------------------------------------------------------------
// Matrix multiply row range
// Holds DIM by DIM matrices A, B and C of signed Q16.16 words in three
// memories, each with one registered read port and one write port. Element
// writes, unknown requests and empty runs complete on the request cycle,
// a read of C through the read state. A run over rows first..last passes
// the request cycle, one multiply-accumulate per cycle set by the one read
// port of A and of B, and a drain of the MAC pipeline. C reads as zero
// after reset through one valid bit per cell, so no clearing pass runs.
// A finished result waits in the output register while the next request is
// taken, and a skid register holds one more.
// ----------------------------------------------------------------------------
`include "matrix_multiply_row_range_macros.svh"

module matrix_multiply_row_range (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mmrr_pkg::in_req_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mmrr_pkg::out_resp_t out_data
);

  logic signed [mmrr_pkg::DATA_W-1:0] mem_a [mmrr_pkg::CELLS];
  logic signed [mmrr_pkg::DATA_W-1:0] mem_b [mmrr_pkg::CELLS];
  logic signed [mmrr_pkg::DATA_W-1:0] mem_c [mmrr_pkg::CELLS];
  logic                               c_vld_r [mmrr_pkg::CELLS];

  mmrr_pkg::state_t                   state_r, state_nxt;
  logic [mmrr_pkg::ROW_W-1:0]         i_r, i_nxt, j_r, j_nxt, k_r, k_nxt, last_r, last_nxt;
  logic                               rd_ok_r, rd_ok_nxt;
  logic signed [mmrr_pkg::DATA_W-1:0] a_q_r, b_q_r, c_q_r, c_init;
  logic                               cv_q_r;
  logic                               out_valid_r, hold_valid_r;
  mmrr_pkg::out_resp_t                out_data_r, hold_data_r;

  logic                               in_acc;
  logic                               req_in_range;
  logic [mmrr_pkg::IDX_W-1:0]         req_idx;
  logic [31:0]                        last_eff;
  logic                               run_empty;
  logic                               k_last, j_last, i_last;
  logic [mmrr_pkg::IDX_W-1:0]         a_rd_addr, b_rd_addr, c_rd_addr;
  logic                               res_v;
  mmrr_pkg::out_resp_t                res_data;
  mmrr_pkg::mac_issue_t               issue;
  mmrr_pkg::mac_wr_t                  mac_wr;
  logic                               mac_busy;

  assign in_ready = (state_r == mmrr_pkg::ST_IDLE) && !hold_valid_r;
  assign in_acc   = in_valid && in_ready;

  assign req_in_range = (32'(in_data.row) < mmrr_pkg::DIM) &&
                        (32'(in_data.col) < mmrr_pkg::DIM);
  assign req_idx      = mmrr_pkg::cell_idx(32'(in_data.row), 32'(in_data.col));
  assign last_eff     = (32'(in_data.last_row) >= mmrr_pkg::DIM) ?
                        32'(mmrr_pkg::DIM - 1) : 32'(in_data.last_row);
  assign run_empty    = (32'(in_data.first_row) >= mmrr_pkg::DIM) ||
                        (32'(in_data.first_row) > last_eff);

  assign k_last = (k_r == mmrr_pkg::ROW_W'(mmrr_pkg::DIM - 1));
  assign j_last = (j_r == mmrr_pkg::ROW_W'(mmrr_pkg::DIM - 1));
  assign i_last = (i_r == last_r);

  assign a_rd_addr = mmrr_pkg::cell_idx(32'(i_r), 32'(k_r));
  assign b_rd_addr = mmrr_pkg::cell_idx(32'(k_r), 32'(j_r));
  assign c_rd_addr = (state_r == mmrr_pkg::ST_RUN) ?
                     mmrr_pkg::cell_idx(32'(i_r), 32'(j_r)) : req_idx;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mmrr_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (in_data.req_type)
            mmrr_pkg::REQ_RUN:  state_nxt = run_empty ? mmrr_pkg::ST_IDLE : mmrr_pkg::ST_RUN;
            mmrr_pkg::REQ_RD_C: state_nxt = mmrr_pkg::ST_READ;
            default:            state_nxt = mmrr_pkg::ST_IDLE;
          endcase
        end
      end
      mmrr_pkg::ST_READ:  state_nxt = mmrr_pkg::ST_IDLE;
      mmrr_pkg::ST_RUN: begin
        if (k_last && j_last && i_last) begin
          state_nxt = mmrr_pkg::ST_DRAIN;
        end
      end
      mmrr_pkg::ST_DRAIN: begin
        if (!mac_busy) begin
          state_nxt = mmrr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mmrr_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    res_v       = 1'b0;
    res_data    = '0;
    issue       = '0;
    issue.cidx  = mmrr_pkg::cell_idx(32'(i_r), 32'(j_r));
    unique case (state_r)
      mmrr_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (in_data.req_type)
            mmrr_pkg::REQ_RUN: begin
              res_v             = run_empty;
              res_data.run_done = 1'b1;
            end
            mmrr_pkg::REQ_RD_C: res_v = 1'b0;
            default:            res_v = 1'b1;
          endcase
        end
      end
      mmrr_pkg::ST_READ: begin
        res_v               = 1'b1;
        res_data.read_value = (rd_ok_r && cv_q_r) ? c_q_r : '0;
      end
      mmrr_pkg::ST_RUN: begin
        issue.v     = 1'b1;
        issue.first = (k_r == '0);
        issue.last  = k_last;
      end
      mmrr_pkg::ST_DRAIN: begin
        res_v             = !mac_busy;
        res_data.run_done = 1'b1;
      end
      default: res_v = 1'b0;
    endcase
  end

  // row, column and k counters
  always_comb begin
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    last_nxt  = last_r;
    rd_ok_nxt = rd_ok_r;
    if (in_acc) begin
      i_nxt     = mmrr_pkg::ROW_W'(in_data.first_row);
      j_nxt     = '0;
      k_nxt     = '0;
      last_nxt  = last_eff[mmrr_pkg::ROW_W-1:0];
      rd_ok_nxt = req_in_range;
    end else if (state_r == mmrr_pkg::ST_RUN) begin
      if (k_last) begin
        k_nxt = '0;
        if (j_last) begin
          j_nxt = '0;
          i_nxt = i_r + 1'b1;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end else begin
        k_nxt = k_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mmrr_pkg::ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
      last_r  <= '0;
      rd_ok_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      last_r  <= last_nxt;
      rd_ok_r <= rd_ok_nxt;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (in_acc && req_in_range && in_data.req_type == mmrr_pkg::REQ_WR_A) begin
      mem_a[req_idx] <= in_data.value;
    end
    a_q_r <= mem_a[a_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (in_acc && req_in_range && in_data.req_type == mmrr_pkg::REQ_WR_B) begin
      mem_b[req_idx] <= in_data.value;
    end
    b_q_r <= mem_b[b_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (mac_wr.en) begin
      mem_c[mac_wr.addr] <= mac_wr.data;
    end else if (in_acc && req_in_range && in_data.req_type == mmrr_pkg::REQ_WR_C) begin
      mem_c[req_idx] <= in_data.value;
    end
    c_q_r <= mem_c[c_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < mmrr_pkg::CELLS; n++) begin
        c_vld_r[mmrr_pkg::IDX_W'(n)] <= 1'b0;
      end
      cv_q_r <= 1'b0;
    end else begin
      if (mac_wr.en) begin
        c_vld_r[mac_wr.addr] <= 1'b1;
      end else if (in_acc && req_in_range && in_data.req_type == mmrr_pkg::REQ_WR_C) begin
        c_vld_r[req_idx] <= 1'b1;
      end
      cv_q_r <= c_vld_r[c_rd_addr];
    end
  end

  assign c_init = cv_q_r ? c_q_r : '0;

  mmrr_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .issue (issue),
    .a_q   (a_q_r),
    .b_q   (b_q_r),
    .c_q   (c_init),
    .wr    (mac_wr),
    .busy  (mac_busy)
  );

  // output register and skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      hold_valid_r <= 1'b0;
    end else if (hold_valid_r) begin
      if (out_ready) begin
        hold_valid_r <= 1'b0;
      end
    end else if (res_v) begin
      if (!out_valid_r || out_ready) begin
        out_valid_r <= 1'b1;
      end else begin
        hold_valid_r <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hold_valid_r) begin
      if (out_ready) begin
        out_data_r <= hold_data_r;
      end
    end else if (res_v) begin
      if (!out_valid_r || out_ready) begin
        out_data_r <= res_data;
      end else begin
        hold_data_r <= res_data;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `MMRR_ASSERT(a_no_result_over_skid, !(res_v && hold_valid_r), "result while skid is full")
  `MMRR_ASSERT_IMP(a_skid_behind_out, hold_valid_r, out_valid_r, "skid holds without output")
  `MMRR_ASSERT_IMP(a_c_write_in_run, mac_wr.en, state_r >= mmrr_pkg::ST_RUN, "C write outside a run")
  `MMRR_ASSERT_IMP(a_idle_mac_quiet, state_r == mmrr_pkg::ST_IDLE, !mac_busy, "MAC busy while idle")

endmodule

>>> rtl/core/mmrr_mac.sv
// ----------------------------------------------------------------------------
// Matrix multiply row range MAC pipeline
// Registers the product of one A and one B element, truncates it to Q16.16
// and adds it with saturation into the running sum of one C cell.
// ----------------------------------------------------------------------------
module mmrr_mac (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mmrr_pkg::mac_issue_t              issue,
  input  logic signed [mmrr_pkg::DATA_W-1:0] a_q,
  input  logic signed [mmrr_pkg::DATA_W-1:0] b_q,
  input  logic signed [mmrr_pkg::DATA_W-1:0] c_q,
  output mmrr_pkg::mac_wr_t                 wr,
  output logic                              busy
);

  mmrr_pkg::mac_issue_t               p1_r;
  mmrr_pkg::mac_issue_t               p2_r;
  logic signed [2*mmrr_pkg::DATA_W-1:0] prod_r;
  logic signed [mmrr_pkg::DATA_W-1:0]   cinit_r;
  logic signed [mmrr_pkg::DATA_W-1:0]   acc_r;
  logic signed [mmrr_pkg::DATA_W-1:0]   acc_nxt;
  logic signed [mmrr_pkg::DATA_W-1:0]   base;
  logic signed [mmrr_pkg::DATA_W+16:0]  sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_r <= '0;
      p2_r <= '0;
    end else begin
      p1_r <= issue;
      p2_r <= p1_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r  <= a_q * b_q;
    cinit_r <= c_q;
    if (p2_r.v) begin
      acc_r <= acc_nxt;
    end
  end

  always_comb begin
    base = p2_r.first ? cinit_r : acc_r;
    sum  = {{17{base[mmrr_pkg::DATA_W-1]}}, base}
         + {prod_r[2*mmrr_pkg::DATA_W-1], prod_r[2*mmrr_pkg::DATA_W-1:16]};
    if (sum[mmrr_pkg::DATA_W+16:mmrr_pkg::DATA_W-1] == '0 ||
        sum[mmrr_pkg::DATA_W+16:mmrr_pkg::DATA_W-1] == '1) begin
      acc_nxt = sum[mmrr_pkg::DATA_W-1:0];
    end else if (sum[mmrr_pkg::DATA_W+16]) begin
      acc_nxt = {1'b1, {(mmrr_pkg::DATA_W-1){1'b0}}};
    end else begin
      acc_nxt = {1'b0, {(mmrr_pkg::DATA_W-1){1'b1}}};
    end
  end

  assign wr.en   = p2_r.v && p2_r.last;
  assign wr.addr = p2_r.cidx;
  assign wr.data = acc_nxt;
  assign busy    = p1_r.v || p2_r.v;

endmodule
